### sv/deq_pkg.sv
// Shared constants, codes and ring arithmetic for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  // Storage geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int OP_W       = 3;
  localparam int ERR_W      = 2;

  // Operation codes; codes above OP_QUERY act as a query.
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  // Ring slot at a given offset from a base slot, wrapped modulo DEPTH.
  // One conditional subtract wraps correctly for any offset up to DEPTH.
  function automatic addr_t slot_at(input addr_t base, input count_t offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return ADDR_W'(sum);
  endfunction

endpackage

### sv/deq_if.sv
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps

interface deq_req_if;
  logic                             valid;
  logic                             ready;
  logic [deq_pkg::OP_W-1:0]         op;
  logic [deq_pkg::DATA_WIDTH-1:0]   value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface deq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [deq_pkg::DATA_WIDTH-1:0]   popped_value;
  logic                             pop_valid;
  logic [deq_pkg::ERR_W-1:0]        error_code;
  logic [deq_pkg::DATA_WIDTH-1:0]   front_value;
  logic [deq_pkg::DATA_WIDTH-1:0]   back_value;
  logic                             is_empty;
  logic [deq_pkg::CNT_W-1:0]        entry_count;

  modport source (output valid, output popped_value, output pop_valid, output error_code,
                  output front_value, output back_value, output is_empty,
                  output entry_count, input ready);
  modport sink   (input valid, input popped_value, input pop_valid, input error_code,
                  input front_value, input back_value, input is_empty,
                  input entry_count, output ready);
endinterface

### sv/deq_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int  DEPTH = 16,
  parameter int  WIDTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/double_ended_queue.sv
// Bounded double-ended queue with ring storage in a synchronous RAM.
// Pushes, queries, refused operations and a pop that empties the queue deliver
// their result word in the cycle after acceptance; a pop that leaves entries behind
// needs one RAM read to refresh the exposed end, so its result word follows that read.
// Throughput: one word per cycle while results drain, but ready stays low during a refresh.
// Reset (synchronous, active high) empties the queue; RAM contents stay undefined.
`timescale 1ns / 1ps

module double_ended_queue (
  input  logic          clk,
  input  logic          rst,
  deq_req_if.sink       req,
  deq_rsp_if.source     rsp
);

  // Ring pointers and cached end entries.
  deq_pkg::addr_t  head;
  deq_pkg::count_t count;
  deq_pkg::data_t  front_q;
  deq_pkg::data_t  back_q;

  // Refresh of one end after a pop is in flight.
  logic pend;
  logic pend_front;

  // Output register.
  logic                         o_valid;
  deq_pkg::data_t               o_popped;
  logic                         o_pop_valid;
  logic [deq_pkg::ERR_W-1:0]    o_err;
  deq_pkg::data_t               o_front;
  deq_pkg::data_t               o_back;
  logic                         o_empty;
  deq_pkg::count_t              o_count;

  // Next-state and result terms.
  logic                         fire;
  logic                         is_full;
  logic                         is_none;
  deq_pkg::addr_t               head_next;
  deq_pkg::count_t              count_next;
  deq_pkg::data_t               front_next;
  deq_pkg::data_t               back_next;
  logic                         wr_en;
  deq_pkg::addr_t               wr_addr;
  logic                         need_read;
  logic                         reload_front;
  deq_pkg::addr_t               rd_addr;
  deq_pkg::data_t               rd_data;
  deq_pkg::data_t               res_popped;
  logic                         res_pop_valid;
  logic [deq_pkg::ERR_W-1:0]    res_err;

  // A word is taken when nothing is in flight and the output register frees up.
  assign req.ready = !pend && (!o_valid || rsp.ready);
  assign fire      = req.valid && req.ready;
  assign is_full   = (count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign is_none   = (count == '0);

  // Decode the operation against the current ring state.
  always_comb begin
    head_next     = head;
    count_next    = count;
    front_next    = front_q;
    back_next     = back_q;
    wr_en         = 1'b0;
    wr_addr       = deq_pkg::slot_at(head, count);
    need_read     = 1'b0;
    reload_front  = 1'b0;
    rd_addr       = head;
    res_popped    = '0;
    res_pop_valid = 1'b0;
    res_err       = deq_pkg::ERR_NONE;
    unique case (req.op)
      deq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          res_err = deq_pkg::ERR_FULL;
        end else begin
          head_next  = (head == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)
                                    : head - deq_pkg::ADDR_W'(1);
          wr_en      = 1'b1;
          wr_addr    = head_next;
          count_next = count + deq_pkg::CNT_W'(1);
          front_next = req.value;
          if (is_none) begin
            back_next = req.value;
          end
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          res_err = deq_pkg::ERR_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = deq_pkg::slot_at(head, count);
          count_next = count + deq_pkg::CNT_W'(1);
          back_next  = req.value;
          if (is_none) begin
            front_next = req.value;
          end
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (is_none) begin
          res_err = deq_pkg::ERR_EMPTY;
        end else begin
          res_popped    = front_q;
          res_pop_valid = 1'b1;
          head_next     = deq_pkg::slot_at(head, deq_pkg::CNT_W'(1));
          count_next    = count - deq_pkg::CNT_W'(1);
          need_read     = (count_next != '0);
          reload_front  = 1'b1;
          rd_addr       = head_next;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (is_none) begin
          res_err = deq_pkg::ERR_EMPTY;
        end else begin
          res_popped    = back_q;
          res_pop_valid = 1'b1;
          count_next    = count - deq_pkg::CNT_W'(1);
          need_read     = (count_next != '0);
          reload_front  = 1'b0;
          rd_addr       = deq_pkg::slot_at(head, count - deq_pkg::CNT_W'(2));
        end
      end
      default: begin
        // Query only; unused codes behave the same.
      end
    endcase
  end

  // Ring storage.
  deq_ram #(
    .DEPTH (deq_pkg::DEPTH),
    .WIDTH (deq_pkg::DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (fire && wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.value),
    .rd_en   (fire && need_read),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control state; a refresh never coincides with a new word, which replaces any drained result.
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      pend    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (fire) begin
        head    <= head_next;
        count   <= count_next;
        pend    <= need_read;
        o_valid <= !need_read;
      end else if (pend) begin
        pend    <= 1'b0;
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Cached ends and the result word; patched by the RAM read when a refresh is due.
  always_ff @(posedge clk) begin
    if (fire) begin
      front_q     <= front_next;
      back_q      <= back_next;
      pend_front  <= reload_front;
      o_popped    <= res_popped;
      o_pop_valid <= res_pop_valid;
      o_err       <= res_err;
      o_front     <= (count_next == '0) ? '0 : front_next;
      o_back      <= (count_next == '0) ? '0 : back_next;
      o_empty     <= (count_next == '0);
      o_count     <= count_next;
    end else if (pend) begin
      if (pend_front) begin
        front_q <= rd_data;
        o_front <= rd_data;
      end else begin
        back_q <= rd_data;
        o_back <= rd_data;
      end
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.popped_value = o_popped;
  assign rsp.pop_valid    = o_pop_valid;
  assign rsp.error_code   = o_err;
  assign rsp.front_value  = o_front;
  assign rsp.back_value   = o_back;
  assign rsp.is_empty     = o_empty;
  assign rsp.entry_count  = o_count;

endmodule

### sv/deq_checker.sv
// Port-level assertions for the double-ended queue and their bind.
`timescale 1ns / 1ps

module deq_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  logic                            pop_valid,
  input  logic [deq_pkg::ERR_W-1:0]       error_code,
  input  logic                            is_empty,
  input  logic [deq_pkg::CNT_W-1:0]       entry_count,
  input  logic [deq_pkg::DATA_WIDTH-1:0]  popped_value
);

  // A stalled result word stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped while stalled");

  // Reset leaves no result word pending.
  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word offered after reset");

  // The empty flag agrees with the entry count, which never exceeds the depth.
  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_count == '0)) &&
                  (entry_count <= deq_pkg::CNT_W'(deq_pkg::DEPTH)))
    else $error("entry count and empty flag disagree");

  // A successful pop carries no error; anything else carries no popped entry.
  a_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (pop_valid ? (error_code == deq_pkg::ERR_NONE) : (popped_value == '0)))
    else $error("pop flag inconsistent with error code or popped entry");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .pop_valid    (rsp.pop_valid),
  .error_code   (rsp.error_code),
  .is_empty     (rsp.is_empty),
  .entry_count  (rsp.entry_count),
  .popped_value (rsp.popped_value)
);

### tb/double_ended_queue_tb.sv
// Self-checking testbench for the double-ended queue, with its own predictor.
`timescale 1ns / 1ps

module double_ended_queue_tb;

  typedef logic [deq_pkg::OP_W-1:0] op_t;

  // One response word as the testbench expects it.
  typedef struct packed {
    deq_pkg::data_t             popped;
    logic                       pop_ok;
    logic [deq_pkg::ERR_W-1:0]  err;
    deq_pkg::data_t             front;
    deq_pkg::data_t             back;
    logic                       empty;
    deq_pkg::count_t            count;
  } deq_result_t;

  // One row of the directed table; a row may repeat with a rising value.
  typedef struct packed {
    op_t             op;
    deq_pkg::data_t  value;
    logic [4:0]      reps;
    logic            lit;
    deq_result_t     want;
  } stim_row_t;

  // Highest unused operation code; the block treats it as a query.
  localparam op_t OP_UNUSED_TOP = 3'd7;

  localparam int RANDOM_ITEMS  = 1080;
  localparam int HOLD_AT_WORD  = 200;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 8;
  localparam int DIR_ROWS      = 12;

  // Results that can be read off directly for an empty queue.
  localparam deq_result_t WANT_EMPTY_POP = '{popped: '0, pop_ok: 1'b0,
                                             err: deq_pkg::ERR_EMPTY,
                                             front: '0, back: '0, empty: 1'b1, count: '0};
  localparam deq_result_t WANT_EMPTY_QUERY = '{popped: '0, pop_ok: 1'b0,
                                               err: deq_pkg::ERR_NONE,
                                               front: '0, back: '0, empty: 1'b1, count: '0};

  // Directed part: empty-queue errors, extremes, a fill to the brim and refusals when full.
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{op: deq_pkg::OP_POP_FRONT,  value: '0,            reps: 5'd1,  lit: 1'b1,
      want: WANT_EMPTY_POP},
    '{op: deq_pkg::OP_POP_BACK,   value: '0,            reps: 5'd1,  lit: 1'b1,
      want: WANT_EMPTY_POP},
    '{op: OP_UNUSED_TOP,          value: '1,            reps: 5'd1,  lit: 1'b1,
      want: WANT_EMPTY_QUERY},
    '{op: deq_pkg::OP_PUSH_FRONT, value: '1,            reps: 5'd1,  lit: 1'b0, want: '0},
    '{op: deq_pkg::OP_PUSH_BACK,  value: '0,            reps: 5'd1,  lit: 1'b0, want: '0},
    '{op: deq_pkg::OP_POP_BACK,   value: '1,            reps: 5'd1,  lit: 1'b0, want: '0},
    '{op: deq_pkg::OP_POP_FRONT,  value: '0,            reps: 5'd1,  lit: 1'b0, want: '0},
    '{op: deq_pkg::OP_PUSH_BACK,  value: 32'h8000_0001, reps: 5'd15, lit: 1'b0, want: '0},
    '{op: deq_pkg::OP_PUSH_FRONT, value: 32'h7FFF_FFFE, reps: 5'd2,  lit: 1'b0, want: '0},
    '{op: deq_pkg::OP_PUSH_BACK,  value: 32'hDEAD_BEEF, reps: 5'd1,  lit: 1'b0, want: '0},
    '{op: deq_pkg::OP_QUERY,      value: 32'h1234_5678, reps: 5'd1,  lit: 1'b0, want: '0},
    '{op: deq_pkg::OP_POP_FRONT,  value: '0,            reps: 5'd2,  lit: 1'b0, want: '0}
  };

  logic clk = 1'b0;
  logic rst;

  deq_req_if req_ch ();
  deq_rsp_if rsp_ch ();

  double_ended_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the queue contents.
  deq_pkg::data_t  shadow_ring [deq_pkg::DEPTH];
  deq_pkg::addr_t  shadow_head = '0;
  deq_pkg::count_t shadow_held = '0;

  deq_result_t pending_words [$];
  int fail_count      = 0;
  int words_seen      = 0;
  int source_idle_pct = 0;
  int sink_idle_pct   = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;

  // Applies one operation to the shadow queue and returns the word it should produce.
  function automatic deq_result_t step_deque(input op_t op, input deq_pkg::data_t val);
    deq_result_t r;
    deq_pkg::addr_t slot;
    r = '0;
    case (op)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (int'(shadow_held) >= deq_pkg::DEPTH) begin
          r.err = deq_pkg::ERR_FULL;
        end else if (op == deq_pkg::OP_PUSH_FRONT) begin
          shadow_head = deq_pkg::addr_t'((int'(shadow_head) + deq_pkg::DEPTH - 1)
                                         % deq_pkg::DEPTH);
          shadow_ring[shadow_head] = val;
          shadow_held = shadow_held + 1'b1;
        end else begin
          slot = deq_pkg::addr_t'((int'(shadow_head) + int'(shadow_held)) % deq_pkg::DEPTH);
          shadow_ring[slot] = val;
          shadow_held = shadow_held + 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (shadow_held == '0) begin
          r.err = deq_pkg::ERR_EMPTY;
        end else if (op == deq_pkg::OP_POP_FRONT) begin
          r.popped = shadow_ring[shadow_head];
          r.pop_ok = 1'b1;
          shadow_head = deq_pkg::addr_t'((int'(shadow_head) + 1) % deq_pkg::DEPTH);
          shadow_held = shadow_held - 1'b1;
        end else begin
          slot = deq_pkg::addr_t'((int'(shadow_head) + int'(shadow_held) - 1)
                                  % deq_pkg::DEPTH);
          r.popped = shadow_ring[slot];
          r.pop_ok = 1'b1;
          shadow_held = shadow_held - 1'b1;
        end
      end
      default: begin
      end
    endcase
    // The exposed ends are only read while something is held.
    if (shadow_held != '0) begin
      slot    = deq_pkg::addr_t'((int'(shadow_head) + int'(shadow_held) - 1)
                                 % deq_pkg::DEPTH);
      r.front = shadow_ring[shadow_head];
      r.back  = shadow_ring[slot];
    end
    r.empty = (shadow_held == '0);
    r.count = shadow_held;
    return r;
  endfunction

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  // Compares one accepted response word with the oldest expectation.
  task automatic check_word();
    deq_result_t want;
    if (pending_words.size() == 0) begin
      $display("%0t ns: response word with nothing expected, actual front %0h count %0d",
               $time, rsp_ch.front_value, rsp_ch.entry_count);
      fail_count++;
    end else begin
      want = pending_words[0];
      pending_words.delete(0);
      report_field("popped_value", 64'(want.popped), 64'(rsp_ch.popped_value));
      report_field("pop_valid",    64'(want.pop_ok), 64'(rsp_ch.pop_valid));
      report_field("error_code",   64'(want.err),    64'(rsp_ch.error_code));
      report_field("front_value",  64'(want.front),  64'(rsp_ch.front_value));
      report_field("back_value",   64'(want.back),   64'(rsp_ch.back_value));
      report_field("is_empty",     64'(want.empty),  64'(rsp_ch.is_empty));
      report_field("entry_count",  64'(want.count),  64'(rsp_ch.entry_count));
    end
    words_seen++;
  endtask

  // Response side: check each accepted word, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_word();
      end
      // One long hold-off so the stalled result word pushes back on the request side.
      if (!hold_done && words_seen >= HOLD_AT_WORD) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // Offers one request word, waits for its acceptance and records the expected result.
  task automatic send_word(input op_t op, input deq_pkg::data_t val, input logic lit,
                           input deq_result_t want);
    deq_result_t predicted;
    if ($urandom_range(0, 99) < source_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = step_deque(op, val);
    if (lit) begin
      predicted = want;
    end
    pending_words = {pending_words, predicted};
  endtask

  // Stops offering until every expected word has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic deq_pkg::data_t pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return deq_pkg::data_t'($urandom());
    endcase
  endfunction

  // Main stimulus.
  initial begin
    int fill_bias;
    op_t op;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.op    <= deq_pkg::OP_QUERY;
    req_ch.value <= '0;
    fill_bias = 50;
    source_idle_pct = 21;
    sink_idle_pct   = 78;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      for (int k = 0; k < int'(DIRECTED[i].reps); k++) begin
        send_word(DIRECTED[i].op, DIRECTED[i].value + deq_pkg::data_t'(k), DIRECTED[i].lit,
                  DIRECTED[i].want);
      end
    end
    wait_drained();

    // Random part in three idling phases; the fill bias drifts so the queue
    // swings between empty and full.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        wait_drained();
        source_idle_pct = 78;
        sink_idle_pct   = 21;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        wait_drained();
        source_idle_pct = 0;
        sink_idle_pct   = 0;
      end
      if (n % 48 == 0) begin
        case ($urandom_range(0, 2))
          0:       fill_bias = 20;
          1:       fill_bias = 50;
          default: fill_bias = 80;
        endcase
      end
      if ($urandom_range(0, 99) < 6) begin
        op = op_t'(deq_pkg::OP_QUERY + op_t'($urandom_range(0, 3)));
      end else if ($urandom_range(0, 99) < fill_bias) begin
        op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
      end
      send_word(op, pick_value(), 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** double_ended_queue: PASSED **");
    end else begin
      $display("** double_ended_queue: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1_000_000;
    $display("** double_ended_queue: FAILED **");
    $finish;
  end

endmodule

### double_ended_queue.f
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_ram.sv
sv/double_ended_queue.sv
sv/deq_checker.sv
tb/double_ended_queue_tb.sv
